/* rtl/qte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg: shared constants, types and tables
// Widths, angle constants and the CORDIC arctangent table used by the
// quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int QTE_ANGLE_FRAC_BITS = 4;
	localparam int QUAT_W = 16;
	localparam int ROLL_W = 13;
	localparam int PITCH_W = 12;
	localparam int YAW_W = 13;

	localparam int PROD_W = 32;
	localparam int SUM_W = 34;
	localparam int S_W = 30;
	localparam int ROOT_W = 29;
	localparam int REM_W = 58;
	localparam int SQRT_STEPS = 29;

	localparam int ACC_FRAC = 16;
	localparam int CW = 44;
	localparam int ZW = 26;
	localparam int NORM_TOP = 40;
	localparam int NORM_STEPS = 6;
	localparam int CORDIC_STEPS = 23;
	localparam int ATAN_LAT = 1 + NORM_STEPS + CORDIC_STEPS + 1;

	localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

	typedef struct packed {
		logic zero;
		logic neg;
		logic pos;
	} atan_flags_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ZW-1:0] r;
		case (idx)
			5'd0: r = ZW'(2949120);
			5'd1: r = ZW'(1740967);
			5'd2: r = ZW'(919879);
			5'd3: r = ZW'(466945);
			5'd4: r = ZW'(234379);
			5'd5: r = ZW'(117304);
			5'd6: r = ZW'(58666);
			5'd7: r = ZW'(29335);
			5'd8: r = ZW'(14668);
			5'd9: r = ZW'(7334);
			5'd10: r = ZW'(3667);
			5'd11: r = ZW'(1833);
			5'd12: r = ZW'(917);
			5'd13: r = ZW'(458);
			5'd14: r = ZW'(229);
			5'd15: r = ZW'(115);
			5'd16: r = ZW'(57);
			5'd17: r = ZW'(29);
			5'd18: r = ZW'(14);
			5'd19: r = ZW'(7);
			5'd20: r = ZW'(4);
			5'd21: r = ZW'(2);
			5'd22: r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/quaternion_to_euler_angles.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: ZYX Euler angles from a Q2.14 quaternion
// Accepts one quaternion word per clock and returns roll, pitch and yaw in
// 1/16 degree after three product and sum stages, a 29-stage square root for
// the pitch cosine and a 31-stage CORDIC arctangent per angle. The whole
// pipeline holds while a result is stalled; otherwise one word enters and
// one leaves every cycle. Input is not normalized; pitch saturates at
// ninety degrees.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
	parameter int ANGLE_FRAC_BITS = qte_pkg::QTE_ANGLE_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [qte_pkg::QUAT_W-1:0]   quat_w,
	input  logic signed [qte_pkg::QUAT_W-1:0]   quat_x,
	input  logic signed [qte_pkg::QUAT_W-1:0]   quat_y,
	input  logic signed [qte_pkg::QUAT_W-1:0]   quat_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [qte_pkg::ROLL_W-1:0]   roll_angle,
	output logic signed [qte_pkg::PITCH_W-1:0]  pitch_angle,
	output logic signed [qte_pkg::YAW_W-1:0]    yaw_angle
);
	import qte_pkg::*;

	localparam int LAT = 3 + SQRT_STEPS + ATAN_LAT;
	localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) <<< 28;

	logic adv;
	logic [LAT-1:0] vld_q;

	logic signed [PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, wy_s1, zx_s1, zz_s1;
	logic signed [SUM_W-1:0] rn_s2, rd_s2, yn_s2, yd_s2;
	logic signed [S_W-1:0] s_s2;
	logic [ROOT_W-1:0] a_s2;
	logic [S_W-1:0] b_s2;
	logic signed [SUM_W-1:0] s_raw;
	logic signed [SUM_W-1:0] s_clip;
	logic [SUM_W-1:0] s_abs;

	logic signed [SUM_W-1:0] sq_rn_s [SQRT_STEPS+1];
	logic signed [SUM_W-1:0] sq_rd_s [SQRT_STEPS+1];
	logic signed [SUM_W-1:0] sq_yn_s [SQRT_STEPS+1];
	logic signed [SUM_W-1:0] sq_yd_s [SQRT_STEPS+1];
	logic signed [S_W-1:0]   sq_s_s  [SQRT_STEPS+1];
	logic [REM_W-1:0]        sq_rem_s [SQRT_STEPS+1];
	logic [ROOT_W-1:0]       sq_root_s [SQRT_STEPS+1];

	logic [ROLL_W-1:0] roll_a;
	logic [PITCH_W-1:0] pitch_a;
	logic [YAW_W-1:0] yaw_a;

	assign adv = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= PROD_W'(quat_w * quat_x);
			yz_s1 <= PROD_W'(quat_y * quat_z);
			xx_s1 <= PROD_W'(quat_x * quat_x);
			yy_s1 <= PROD_W'(quat_y * quat_y);
			wz_s1 <= PROD_W'(quat_w * quat_z);
			xy_s1 <= PROD_W'(quat_x * quat_y);
			wy_s1 <= PROD_W'(quat_w * quat_y);
			zx_s1 <= PROD_W'(quat_z * quat_x);
			zz_s1 <= PROD_W'(quat_z * quat_z);
		end
	end

	always_comb begin
		s_raw = (SUM_W'(wy_s1) - SUM_W'(zx_s1)) <<< 1;
		s_clip = s_raw;
		if (s_raw > ONE_Q28) begin
			s_clip = ONE_Q28;
		end
		if (s_raw < -ONE_Q28) begin
			s_clip = -ONE_Q28;
		end
		s_abs = (s_clip < 0) ? SUM_W'(-s_clip) : SUM_W'(s_clip);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rn_s2 <= (SUM_W'(wx_s1) + SUM_W'(yz_s1)) <<< 1;
			rd_s2 <= ONE_Q28 - ((SUM_W'(xx_s1) + SUM_W'(yy_s1)) <<< 1);
			yn_s2 <= (SUM_W'(wz_s1) + SUM_W'(xy_s1)) <<< 1;
			yd_s2 <= ONE_Q28 - ((SUM_W'(yy_s1) + SUM_W'(zz_s1)) <<< 1);
			s_s2 <= s_clip[S_W-1:0];
			a_s2 <= ROOT_W'(ONE_Q28 - s_abs);
			b_s2 <= S_W'(ONE_Q28 + s_abs);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rn_s[0] <= rn_s2;
			sq_rd_s[0] <= rd_s2;
			sq_yn_s[0] <= yn_s2;
			sq_yd_s[0] <= yd_s2;
			sq_s_s[0] <= s_s2;
			sq_rem_s[0] <= REM_W'({29'd0, a_s2} * {28'd0, b_s2});
			sq_root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam int I = SQRT_STEPS - 1 - j;
		logic [REM_W-1:0] trial;
		assign trial = (REM_W'(sq_root_s[j]) << (I + 1)) + (REM_W'(1) << (2 * I));
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rn_s[j+1] <= sq_rn_s[j];
				sq_rd_s[j+1] <= sq_rd_s[j];
				sq_yn_s[j+1] <= sq_yn_s[j];
				sq_yd_s[j+1] <= sq_yd_s[j];
				sq_s_s[j+1] <= sq_s_s[j];
				if (sq_rem_s[j] >= trial) begin
					sq_rem_s[j+1] <= sq_rem_s[j] - trial;
					sq_root_s[j+1] <= sq_root_s[j] | (ROOT_W'(1) << I);
				end else begin
					sq_rem_s[j+1] <= sq_rem_s[j];
					sq_root_s[j+1] <= sq_root_s[j];
				end
			end
		end
	end

	qte_atan2 #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.OUT_W(ROLL_W),
		.LIMIT_DEG(180)
	) u_roll (
		.clk(clk),
		.en(adv),
		.num(CW'(sq_rn_s[SQRT_STEPS])),
		.den(CW'(sq_rd_s[SQRT_STEPS])),
		.angle(roll_a)
	);

	qte_atan2 #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.OUT_W(PITCH_W),
		.LIMIT_DEG(90)
	) u_pitch (
		.clk(clk),
		.en(adv),
		.num(CW'(sq_s_s[SQRT_STEPS])),
		.den(CW'({1'b0, sq_root_s[SQRT_STEPS]})),
		.angle(pitch_a)
	);

	qte_atan2 #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.OUT_W(YAW_W),
		.LIMIT_DEG(180)
	) u_yaw (
		.clk(clk),
		.en(adv),
		.num(CW'(sq_yn_s[SQRT_STEPS])),
		.den(CW'(sq_yd_s[SQRT_STEPS])),
		.angle(yaw_a)
	);

	assign roll_angle = roll_a;
	assign pitch_angle = pitch_a;
	assign yaw_angle = yaw_a;

endmodule

/* rtl/qte_atan2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_atan2: pipelined four-quadrant arctangent
// Folds the vector into the right half plane, normalizes it in six shift
// stages, runs 23 vectoring CORDIC stages and rounds and clamps the angle.
// ----------------------------------------------------------------------------
module qte_atan2 #(
	parameter int ANGLE_FRAC_BITS = qte_pkg::QTE_ANGLE_FRAC_BITS,
	parameter int OUT_W = qte_pkg::ROLL_W,
	parameter int LIMIT_DEG = 180
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [qte_pkg::CW-1:0] num,
	input  logic signed [qte_pkg::CW-1:0] den,
	output logic        [OUT_W-1:0]       angle
);
	import qte_pkg::*;

	localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int FL = NORM_STEPS + CORDIC_STEPS + 1;
	localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH - 1);
	localparam logic signed [ZW-1:0] LIM = ZW'((LIMIT_DEG * 65536) >> SH);

	logic signed [CW-1:0] nx_s [NORM_STEPS+1];
	logic signed [CW-1:0] ny_s [NORM_STEPS+1];
	logic signed [CW-1:0] cx_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] cy_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] cz_s [CORDIC_STEPS+1];
	atan_flags_t          fl_s [FL];

	logic signed [ZW-1:0] acc;
	logic signed [ZW-1:0] rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s[0].zero <= (num == '0);
			fl_s[0].neg <= (den < 0);
			fl_s[0].pos <= (num > 0);
			nx_s[0] <= (den < 0) ? -den : den;
			ny_s[0] <= (den < 0) ? -num : num;
			for (int k = 1; k < FL; k++) begin
				fl_s[k] <= fl_s[k-1];
			end
		end
	end

	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
		localparam int A = 1 << (NORM_STEPS - 1 - k);
		logic [CW-1:0] mag;
		assign mag = nx_s[k] | ((ny_s[k] < 0) ? -ny_s[k] : ny_s[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				if ((mag >> (NORM_TOP + 1 - A)) == '0) begin
					nx_s[k+1] <= nx_s[k] <<< A;
					ny_s[k+1] <= ny_s[k] <<< A;
				end else begin
					nx_s[k+1] <= nx_s[k];
					ny_s[k+1] <= ny_s[k];
				end
			end
		end
	end

	assign cx_s[0] = nx_s[NORM_STEPS];
	assign cy_s[0] = ny_s[NORM_STEPS];
	assign cz_s[0] = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [ZW-1:0] da;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign da = atan_entry(5'(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[i] > 0) begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + da;
				end else begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - da;
				end
			end
		end
	end

	always_comb begin
		if (fl_s[FL-1].zero) begin
			acc = fl_s[FL-1].neg ? DEG180 : '0;
		end else if (fl_s[FL-1].neg) begin
			acc = cz_s[CORDIC_STEPS] + (fl_s[FL-1].pos ? DEG180 : -DEG180);
		end else begin
			acc = cz_s[CORDIC_STEPS];
		end
		rnd = (acc + HALF) >>> SH;
		if (rnd > LIM) begin
			rnd = LIM;
		end
		if (rnd < -LIM) begin
			rnd = -LIM;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= rnd[OUT_W-1:0];
		end
	end

endmodule
